[hdl/http_byte_range_parser_assert.svh]
// ----------------------------------------------------------------------------
// http_byte_range_parser_assert.svh
// assertion macros used by the range parser resolver, http_brp_back
// ----------------------------------------------------------------------------
`ifndef HTTP_BYTE_RANGE_PARSER_ASSERT_SVH
`define HTTP_BYTE_RANGE_PARSER_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define BRP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error(msg);

// condition in one cycle implies a condition in the next
`define BRP_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error(msg);

`endif

[hdl/http_brp_pkg.sv]
// ----------------------------------------------------------------------------
// http_brp_pkg
// types, constants and helpers of the byte range parser
// ----------------------------------------------------------------------------
package http_brp_pkg;

	localparam int VALUE_BITS = 48;
	localparam int FIELD_BITS = 48;
	localparam int LEN_BITS   = FIELD_BITS + 1;
	localparam int CW         = (VALUE_BITS > FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
	localparam int PREFIX_LEN = 6;
	localparam int QDEPTH     = 2;
	localparam int QAW        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	localparam logic [VALUE_BITS-1:0] NUM_MAX = '1;

	localparam logic [7:0] CH_DASH = 8'h2d;
	localparam logic [7:0] CH_PLUS = 8'h2b;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;

	typedef enum logic [3:0] {
		PH_PREFIX = 4'b0001,
		PH_FIRST  = 4'b0010,
		PH_SECOND = 4'b0100,
		PH_ERROR  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic seen;
		logic sign;
		logic ovf;
	} num_flags_t;

	typedef struct packed {
		logic                  ok;
		logic [VALUE_BITS-1:0] num;
		num_flags_t            flags;
	} num_step_t;

	// parse outcome handed from front to back at the last character
	typedef struct packed {
		logic                  in_second;
		num_flags_t            flags1;
		num_flags_t            flags2;
		logic [VALUE_BITS-1:0] num1;
		logic [VALUE_BITS-1:0] num2;
		logic [FIELD_BITS-1:0] file_size;
	} finish_req_t;

	// characters of the "bytes=" prefix
	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] r;
		case (pos)
			3'd0: r = 8'h62;
			3'd1: r = 8'h79;
			3'd2: r = 8'h74;
			3'd3: r = 8'h65;
			3'd4: r = 8'h73;
			3'd5: r = 8'h3d;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// one character of a decimal number with optional leading plus
	function automatic num_step_t num_step(input logic [7:0] c,
			input logic [VALUE_BITS-1:0] num, input num_flags_t flags);
		num_step_t             r;
		logic [VALUE_BITS+3:0] wide;
		r.ok    = 1'b0;
		r.num   = num;
		r.flags = flags;
		wide = ({4'b0000, num} << 3) + ({4'b0000, num} << 1)
			+ {{VALUE_BITS{1'b0}}, c[3:0]};
		if (c >= CH_0 && c <= CH_9) begin
			r.ok         = 1'b1;
			r.flags.seen = 1'b1;
			if (wide[VALUE_BITS+3:VALUE_BITS] != 4'b0000) begin
				r.num       = NUM_MAX;
				r.flags.ovf = 1'b1;
			end else begin
				r.num = wide[VALUE_BITS-1:0];
			end
		end else if (c == CH_PLUS && !flags.seen && !flags.sign) begin
			r.ok         = 1'b1;
			r.flags.sign = 1'b1;
		end
		return r;
	endfunction

endpackage

[hdl/http_brp_in_if.sv]
// ----------------------------------------------------------------------------
// http_brp_in_if
// header character channel
// ----------------------------------------------------------------------------
interface http_brp_in_if;
	import http_brp_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [7:0]            character;
	logic                  char_present;
	logic                  last_char;
	logic [FIELD_BITS-1:0] file_size;

	modport source (output valid, character, char_present, last_char, file_size,
		input ready);
	modport sink (input valid, character, char_present, last_char, file_size,
		output ready);
endinterface

[hdl/http_brp_out_if.sv]
// ----------------------------------------------------------------------------
// http_brp_out_if
// parsed range result channel
// ----------------------------------------------------------------------------
interface http_brp_out_if;
	import http_brp_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  range_valid;
	logic [FIELD_BITS-1:0] range_start;
	logic [FIELD_BITS-1:0] range_end;
	logic [LEN_BITS-1:0]   range_length;

	modport source (output valid, range_valid, range_start, range_end, range_length,
		input ready);
	modport sink (input valid, range_valid, range_start, range_end, range_length,
		output ready);
endinterface

[hdl/http_brp_front.sv]
// ----------------------------------------------------------------------------
// http_brp_front
// character scanner: prefix match, dash split and number accumulation
// ----------------------------------------------------------------------------
module http_brp_front (
	input  logic                      clk,
	input  logic                      arst_n,
	http_brp_in_if.sink               hdr,
	input  logic                      q_full,
	output logic                      req_valid,
	output http_brp_pkg::finish_req_t req
);
	import http_brp_pkg::*;

	phase_t                phase_q, phase_n;
	logic [2:0]            pos_q, pos_n;
	logic [VALUE_BITS-1:0] num1_q, num1_n, num2_q, num2_n;
	num_flags_t            flags1_q, flags1_n, flags2_q, flags2_n;
	num_step_t             st1, st2;
	logic                  take;

	assign hdr.ready = !q_full;
	assign take      = hdr.valid && hdr.ready;

	assign st1 = num_step(hdr.character, num1_q, flags1_q);
	assign st2 = num_step(hdr.character, num2_q, flags2_q);

	// next parse state for the current character
	always_comb begin
		phase_n  = phase_q;
		pos_n    = pos_q;
		num1_n   = num1_q;
		num2_n   = num2_q;
		flags1_n = flags1_q;
		flags2_n = flags2_q;
		if (hdr.char_present) begin
			case (phase_q)
				PH_PREFIX: begin
					if (pos_q < 3'(PREFIX_LEN) && hdr.character == prefix_char(pos_q)) begin
						pos_n = pos_q + 3'd1;
						if (pos_q == 3'(PREFIX_LEN - 1)) begin
							phase_n = PH_FIRST;
						end
					end else begin
						phase_n = PH_ERROR;
					end
				end
				PH_FIRST: begin
					if (hdr.character == CH_DASH) begin
						phase_n = PH_SECOND;
					end else if (st1.ok) begin
						num1_n   = st1.num;
						flags1_n = st1.flags;
					end else begin
						phase_n = PH_ERROR;
					end
				end
				PH_SECOND: begin
					if (st2.ok) begin
						num2_n   = st2.num;
						flags2_n = st2.flags;
					end else begin
						phase_n = PH_ERROR;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// finish request on the last character
	assign req_valid     = take && hdr.last_char;
	assign req.in_second = (phase_n == PH_SECOND);
	assign req.flags1    = flags1_n;
	assign req.flags2    = flags2_n;
	assign req.num1      = num1_n;
	assign req.num2      = num2_n;
	assign req.file_size = hdr.file_size;

	// parse state, cleared after each header
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PREFIX;
			pos_q    <= '0;
			num1_q   <= '0;
			num2_q   <= '0;
			flags1_q <= '0;
			flags2_q <= '0;
		end else if (take) begin
			if (hdr.last_char) begin
				phase_q  <= PH_PREFIX;
				pos_q    <= '0;
				num1_q   <= '0;
				num2_q   <= '0;
				flags1_q <= '0;
				flags2_q <= '0;
			end else begin
				phase_q  <= phase_n;
				pos_q    <= pos_n;
				num1_q   <= num1_n;
				num2_q   <= num2_n;
				flags1_q <= flags1_n;
				flags2_q <= flags2_n;
			end
		end
	end
endmodule

[hdl/http_brp_queue.sv]
// ----------------------------------------------------------------------------
// http_brp_queue
// short register queue of finish requests between front and back
// ----------------------------------------------------------------------------
module http_brp_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  http_brp_pkg::finish_req_t push_data,
	input  logic                      pop,
	output logic                      full,
	output logic                      head_valid,
	output http_brp_pkg::finish_req_t head
);
	import http_brp_pkg::*;

	finish_req_t    mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_push, do_pop;

	assign full       = (count_q == (QAW+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

[hdl/http_brp_back.sv]
// ----------------------------------------------------------------------------
// http_brp_back
// range resolution: suffix and open forms, clamping, checks and length
// ----------------------------------------------------------------------------
module http_brp_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  http_brp_pkg::finish_req_t q_head,
	output logic                      q_pop,
	http_brp_out_if.source            rng
);
	import http_brp_pkg::*;
	`include "http_byte_range_parser_assert.svh"

	logic                  v_s1, v_s2, v_s3, ov_q;
	logic                  en_s1, en_s2, en_s3, en_out;
	finish_req_t           req_s1;
	logic [CW-1:0]         fs, n1, n2, fsm1, start_c, end_c;
	logic                  bad_c;
	logic                  bad_s2;
	logic [CW-1:0]         start_s2, end_s2, fsm1_s2, fs_s2;
	logic [CW-1:0]         end_cl;
	logic                  ok_c;
	logic                  ok_s3;
	logic [FIELD_BITS-1:0] start_s3, end_s3;
	logic                  rv_q;
	logic [FIELD_BITS-1:0] start_q, end_q;
	logic [LEN_BITS-1:0]   len_q;

	// stall chain
	assign en_out = !ov_q || rng.ready;
	assign en_s3  = !v_s3 || en_out;
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;
	assign q_pop  = q_valid && en_s1;

	// stage 1: choose form, raw start and end
	always_comb begin
		fs      = CW'(req_s1.file_size);
		n1      = CW'(req_s1.num1);
		n2      = CW'(req_s1.num2);
		fsm1    = fs - 1'b1;
		bad_c   = !req_s1.in_second || (fs == '0);
		start_c = n1;
		end_c   = fsm1;
		if (!req_s1.flags1.seen && !req_s1.flags1.sign) begin
			// suffix form takes the last bytes
			bad_c   = bad_c || !req_s1.flags2.seen || (n2 == '0);
			start_c = (n2 >= fs) ? '0 : fs - n2;
		end else begin
			bad_c = bad_c || !req_s1.flags1.seen;
			if (req_s1.flags2.seen || req_s1.flags2.sign) begin
				bad_c = bad_c || !req_s1.flags2.seen;
				end_c = n2;
			end
		end
	end

	// stage 2: clamp end and check start
	assign end_cl = (end_s2 > fsm1_s2) ? fsm1_s2 : end_s2;
	assign ok_c   = !bad_s2 && !(start_s2 > end_cl) && !(start_s2 >= fs_s2);

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= q_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_out) ov_q <= v_s3;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (en_s1 && q_valid) begin
			req_s1 <= q_head;
		end
		if (en_s2 && v_s1) begin
			bad_s2   <= bad_c;
			start_s2 <= start_c;
			end_s2   <= end_c;
			fsm1_s2  <= fsm1;
			fs_s2    <= fs;
		end
		if (en_s3 && v_s2) begin
			ok_s3    <= ok_c;
			start_s3 <= FIELD_BITS'(start_s2);
			end_s3   <= FIELD_BITS'(end_cl);
		end
		if (en_out && v_s3) begin
			rv_q    <= ok_s3;
			start_q <= ok_s3 ? start_s3 : '0;
			end_q   <= ok_s3 ? end_s3 : '0;
			len_q   <= ok_s3 ? (LEN_BITS'(end_s3) - LEN_BITS'(start_s3) + 1'b1) : '0;
		end
	end

	assign rng.valid        = ov_q;
	assign rng.range_valid  = rv_q;
	assign rng.range_start  = start_q;
	assign rng.range_end    = end_q;
	assign rng.range_length = len_q;

	`BRP_ASSERT(a_invalid_zero, !(ov_q && !rv_q) || (start_q == '0 && end_q == '0 && len_q == '0), "invalid result with nonzero fields")
	`BRP_ASSERT(a_start_le_end, !(ov_q && rv_q) || (start_q <= end_q && len_q != '0), "valid range out of order")
	`BRP_ASSERT_NEXT(a_s3_held, v_s3 && !en_out, v_s3, "stalled result lost in stage 3")
	`BRP_ASSERT_NEXT(a_pop_loads, q_pop, v_s1, "popped request not in stage 1")
endmodule

[hdl/http_byte_range_parser.sv]
// a result passes the queue, three resolve stages and output register to reach rng
// throughput: one header character per cycle, results back to back; the scanner
// stalls only on a full two-entry queue, which decouples it from the
// three-stage resolve pipeline and output register, which stall on rng.ready alone
// reset: arst_n asynchronous, clears parse state, queue and pipeline valids
// ----------------------------------------------------------------------------
// http_byte_range_parser
// single-range http range header parser, top level
// ----------------------------------------------------------------------------
module http_byte_range_parser (
	input  logic           clk,
	input  logic           arst_n,
	http_brp_in_if.sink    hdr,
	http_brp_out_if.source rng
);
	import http_brp_pkg::*;

	finish_req_t push_req, head_req;
	logic        push_valid, q_full, q_valid, q_pop;

	// scanner
	http_brp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr       (hdr),
		.q_full    (q_full),
		.req_valid (push_valid),
		.req       (push_req)
	);

	// request queue
	http_brp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_valid),
		.push_data  (push_req),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_valid),
		.head       (head_req)
	);

	// resolver
	http_brp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (head_req),
		.q_pop   (q_pop),
		.rng     (rng)
	);
endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// checks the byte range parser: header strings are streamed one character per
// request with random gaps, results are taken under random back pressure and
// compared field by field against a parser model kept in a small scoreboard
// ----------------------------------------------------------------------------
module testbench;
	import http_brp_pkg::*;

	localparam int RANDOM_ITEMS   = 880;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int MAX_REPORTS    = 10;
	localparam logic [63:0] VALUE_MAX = (64'd1 << VALUE_BITS) - 64'd1;
	localparam logic [FIELD_BITS-1:0] FS_MAX = '1;

	// one parsed range as it leaves the block
	typedef struct {
		logic                  ok;
		logic [FIELD_BITS-1:0] start_off;
		logic [FIELD_BITS-1:0] end_off;
		logic [LEN_BITS-1:0]   len;
	} range_t;

	// parser model and queue of ranges still owed by the block
	class range_scoreboard;
		string       prefix_text;
		logic [2:0]  prefix_pos;
		phase_t      phase;
		logic [63:0] start_num;
		logic [63:0] end_num;
		num_flags_t  start_flags;
		num_flags_t  end_flags;
		range_t      owed_q[$];
		int          failures;

		function new();
			prefix_text = "bytes=";
			failures = 0;
			clear();
		endfunction

		function void clear();
			prefix_pos = '0;
			phase = PH_PREFIX;
			start_num = '0;
			end_num = '0;
			start_flags = '0;
			end_flags = '0;
		endfunction

		function void note_failure(string msg);
			failures++;
			if (failures <= MAX_REPORTS) begin
				$display("%s", msg);
			end
		endfunction

		// decimal digit or leading plus; returns 0 on a syntax error
		function bit take_digit(input logic [7:0] c, inout logic [63:0] num,
				inout num_flags_t fl);
			logic [63:0] d;
			d = 64'(c - CH_0);
			if (c >= CH_0 && c <= CH_9) begin
				if (num > (VALUE_MAX - d) / 64'd10) begin
					num = VALUE_MAX;
					fl.ovf = 1'b1;
				end else begin
					num = num * 64'd10 + d;
				end
				fl.seen = 1'b1;
				return 1'b1;
			end
			if (c == CH_PLUS && !fl.seen && !fl.sign) begin
				fl.sign = 1'b1;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void take_char(input logic [7:0] c);
			case (phase)
				PH_PREFIX: begin
					if (prefix_pos < PREFIX_LEN && c == 8'(prefix_text[prefix_pos])) begin
						prefix_pos++;
						if (prefix_pos == PREFIX_LEN) begin
							phase = PH_FIRST;
						end
					end else begin
						phase = PH_ERROR;
					end
				end
				PH_FIRST: begin
					if (c == CH_DASH) begin
						phase = PH_SECOND;
					end else if (!take_digit(c, start_num, start_flags)) begin
						phase = PH_ERROR;
					end
				end
				PH_SECOND: begin
					if (!take_digit(c, end_num, end_flags)) begin
						phase = PH_ERROR;
					end
				end
				default: ;
			endcase
		endfunction

		// turn the parsed numbers into a range against the file size
		function range_t resolve(input logic [63:0] fs);
			range_t      r;
			logic [63:0] lo;
			logic [63:0] hi;
			bit          start_empty;
			bit          end_empty;
			r = '{ok: 1'b0, start_off: '0, end_off: '0, len: '0};
			start_empty = !start_flags.seen && !start_flags.sign;
			end_empty = !end_flags.seen && !end_flags.sign;
			if (phase != PH_SECOND || fs == 0) begin
				return r;
			end
			if (start_empty) begin
				// suffix form takes the last bytes of the file
				if (!end_flags.seen || end_num == 0) begin
					return r;
				end
				lo = (end_num >= fs) ? 64'd0 : fs - end_num;
				hi = fs - 64'd1;
			end else begin
				if (!start_flags.seen) begin
					return r;
				end
				lo = start_num;
				if (end_empty) begin
					hi = fs - 64'd1;
				end else if (!end_flags.seen) begin
					return r;
				end else begin
					hi = end_num;
				end
			end
			if (hi > fs - 64'd1) begin
				hi = fs - 64'd1;
			end
			if (lo > hi || lo >= fs) begin
				return r;
			end
			r.ok = 1'b1;
			r.start_off = lo[FIELD_BITS-1:0];
			r.end_off = hi[FIELD_BITS-1:0];
			r.len = LEN_BITS'(hi - lo + 64'd1);
			return r;
		endfunction

		function void note_request(input logic [7:0] c, input bit present, input bit last,
				input logic [FIELD_BITS-1:0] fs);
			if (present) begin
				take_char(c);
			end
			if (last) begin
				owed_q.push_back(resolve(64'(fs)));
				clear();
			end
		endfunction

		function void check_result(input logic ok, input logic [FIELD_BITS-1:0] start_off,
				input logic [FIELD_BITS-1:0] end_off, input logic [LEN_BITS-1:0] len);
			range_t want;
			if (owed_q.size() == 0) begin
				note_failure($sformatf("unexpected range: ok=%0b start=%0d end=%0d len=%0d",
					ok, start_off, end_off, len));
				return;
			end
			want = owed_q.pop_front();
			if (ok !== want.ok || start_off !== want.start_off || end_off !== want.end_off
					|| len !== want.len) begin
				note_failure({
					$sformatf("range mismatch: want ok=%0b start=%0d end=%0d len=%0d",
						want.ok, want.start_off, want.end_off, want.len),
					$sformatf(", got ok=%0b start=%0d end=%0d len=%0d",
						ok, start_off, end_off, len)});
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	http_brp_in_if  hdr();
	http_brp_out_if rng();

	http_byte_range_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.hdr(hdr),
		.rng(rng)
	);

	range_scoreboard sb;
	logic [7:0]      hdr_text[$];
	bit              burst_mode;
	int              chars_sent;
	int              quiet_cycles;

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// result side back pressure
	initial begin
		int r;
		int hold;
		bit lvl;
		rng.ready = 1'b0;
		hold = 0;
		lvl = 1'b1;
		forever begin
			@(posedge clk);
			if (burst_mode) begin
				lvl = 1'b1;
				hold = 0;
			end else if (hold == 0) begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					lvl = 1'b1;
					hold = $urandom_range(0, 8);
				end else if (r < 93) begin
					lvl = 1'b0;
					hold = $urandom_range(0, 2);
				end else begin
					lvl = 1'b0;
					hold = $urandom_range(10, 40);
				end
			end else begin
				hold--;
			end
			rng.ready <= lvl;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && rng.valid && rng.ready) begin
			sb.check_result(rng.range_valid, rng.range_start, rng.range_end, rng.range_length);
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (hdr.valid && hdr.ready) || (rng.valid && rng.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", quiet_cycles);
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic int pick_gap();
		int r;
		if (burst_mode) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [FIELD_BITS-1:0] random_size();
		return FIELD_BITS'({$urandom, $urandom});
	endfunction

	// one character request, held until the block takes it
	task automatic send_item(input logic [7:0] c, input bit present, input bit last,
			input logic [FIELD_BITS-1:0] fs);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			hdr.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hdr.valid <= 1'b1;
		hdr.character <= c;
		hdr.char_present <= present;
		hdr.last_char <= last;
		hdr.file_size <= fs;
		do @(posedge clk); while (!hdr.ready);
		sb.note_request(c, present, last, fs);
		if (present) begin
			chars_sent++;
		end
	endtask

	// stream hdr_text, with blank requests mixed in now and then
	task automatic send_header(input logic [FIELD_BITS-1:0] fs, input bit trail_blank);
		int n;
		n = hdr_text.size();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 39) == 0) begin
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, random_size());
			end
			send_item(hdr_text[i], 1'b1, (i == n - 1) && !trail_blank,
				(i == n - 1) ? fs : random_size());
		end
		if (n == 0 || trail_blank) begin
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, fs);
		end
	endtask

	function automatic void put_text(input string t);
		for (int i = 0; i < t.len(); i++) begin
			hdr_text.push_back(8'(t[i]));
		end
	endfunction

	task automatic send_text(input string t, input logic [FIELD_BITS-1:0] fs,
			input bit trail_blank);
		hdr_text.delete();
		put_text(t);
		send_header(fs, trail_blank);
	endtask

	function automatic logic [FIELD_BITS-1:0] pick_file_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			return '0;
		end
		if (r < 8) begin
			return FIELD_BITS'(1);
		end
		if (r < 45) begin
			return FIELD_BITS'($urandom_range(1, 1000));
		end
		if (r < 80) begin
			return random_size();
		end
		if (r < 88) begin
			return FS_MAX;
		end
		return FIELD_BITS'(1) << $urandom_range(1, FIELD_BITS - 1);
	endfunction

	// decimal text, mostly within or near the file size, sometimes beyond the field width
	function automatic string number_text(input logic [FIELD_BITS-1:0] fs);
		logic [63:0] v;
		string       s;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			s = $sformatf("%0d", $urandom_range(1, 9));
			repeat ($urandom_range(14, 19)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
			return s;
		end
		if (r < 50 && fs != 0) begin
			v = {$urandom, $urandom} % 64'(fs);
		end else if (r < 70) begin
			v = $urandom_range(0, 20);
		end else if (r < 85) begin
			v = 64'(fs) + $urandom_range(0, 4) - 64'd2;
		end else begin
			v = 64'(random_size());
		end
		s = $sformatf("%0d", v);
		if ($urandom_range(0, 9) == 0) begin
			s = {"0", s};
		end
		return s;
	endfunction

	function automatic string sign_text();
		return ($urandom_range(0, 6) == 0) ? "+" : "";
	endfunction

	function automatic void build_valid(input logic [FIELD_BITS-1:0] fs);
		string odd_forms[5];
		int    r;
		odd_forms = '{"-", "+-", "-+", "+-+", "5-+"};
		put_text("bytes=");
		r = $urandom_range(0, 99);
		if (r < 35) begin
			put_text({sign_text(), number_text(fs), "-", sign_text(), number_text(fs)});
		end else if (r < 60) begin
			put_text({sign_text(), number_text(fs), "-"});
		end else if (r < 90) begin
			put_text({"-", sign_text(), number_text(fs)});
		end else begin
			put_text(odd_forms[$urandom_range(0, 4)]);
		end
	endfunction

	function automatic logic [7:0] odd_char();
		string picks;
		picks = "-+09= bx";
		if ($urandom_range(0, 1) == 0) begin
			return 8'(picks[$urandom_range(0, picks.len() - 1)]);
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// mostly well formed requests, some damaged, some plain noise
	function automatic void build_header(input logic [FIELD_BITS-1:0] fs);
		int    r;
		int    pos;
		string pfx;
		hdr_text.delete();
		r = $urandom_range(0, 99);
		if (r < 70) begin
			build_valid(fs);
		end else if (r < 90) begin
			build_valid(fs);
			pos = $urandom_range(0, hdr_text.size() - 1);
			case ($urandom_range(0, 4))
				0: hdr_text[pos] = odd_char();
				1: hdr_text.insert(pos, odd_char());
				2: hdr_text.delete(pos);
				3: put_text({"-", number_text(fs)});
				default: hdr_text.insert(pos, CH_PLUS);
			endcase
		end else begin
			if ($urandom_range(0, 2) == 0) begin
				pfx = "bytes=";
				put_text(pfx.substr(0, $urandom_range(0, 4)));
			end
			repeat ($urandom_range(0, 8)) hdr_text.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	// sender holds off until the block has delivered everything owed
	task automatic wait_drained();
		hdr.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic run_directed();
		hdr_text.delete();
		send_header(FIELD_BITS'(1000), 1'b0);
		send_text("bytes=0-499", FIELD_BITS'(1000), 1'b0);
		send_text("bytes=500-", FIELD_BITS'(1000), 1'b0);
		send_text("bytes=-200", FIELD_BITS'(1000), 1'b0);
		send_text("bytes=-0", FIELD_BITS'(1000), 1'b0);
		send_text("bytes=-2000", FIELD_BITS'(1000), 1'b0);
		send_text("bytes=+10-+20", FIELD_BITS'(1000), 1'b0);
		send_text("bytes=+-5", FIELD_BITS'(1000), 1'b0);
		send_text("bytes=-", FIELD_BITS'(1000), 1'b0);
		send_text("bytes=5-4", FIELD_BITS'(1000), 1'b0);
		send_text("bytes=1000-", FIELD_BITS'(1000), 1'b0);
		send_text("bytes=0-99999", FIELD_BITS'(1000), 1'b0);
		send_text("bytes=0-0", '0, 1'b0);
		send_text("bytes=0-0", FIELD_BITS'(1), 1'b0);
		send_text("Bytes=0-1", FIELD_BITS'(1000), 1'b0);
		send_text("bytes=1-2-3", FIELD_BITS'(1000), 1'b0);
		send_text("bytes=1+2-3", FIELD_BITS'(1000), 1'b0);
		send_text("bytes=++1-3", FIELD_BITS'(1000), 1'b0);
		send_text("bytes= 1-3", FIELD_BITS'(1000), 1'b0);
		send_text("bytes=12", FIELD_BITS'(1000), 1'b0);
		send_text("bytes=-5x", FIELD_BITS'(1000), 1'b0);
		send_text("bytes=3-4", FIELD_BITS'(1000), 1'b1);
		send_text("bytes=99999999999999999999-", FS_MAX, 1'b0);
		send_text("bytes=0-99999999999999999999", FS_MAX, 1'b0);
		send_text("bytes=-99999999999999999999", FS_MAX, 1'b0);
		send_text("bytes=281474976710654-", FS_MAX, 1'b0);
	endtask

	// reset, directed requests, then random headers
	initial begin
		int                    base;
		int                    hdr_count;
		logic [FIELD_BITS-1:0] fs;
		sb = new();
		arst_n = 1'b0;
		burst_mode = 1'b0;
		chars_sent = 0;
		hdr.valid = 1'b0;
		hdr.character = '0;
		hdr.char_present = 1'b0;
		hdr.last_char = 1'b0;
		hdr.file_size = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		base = chars_sent;
		hdr_count = 0;
		while (chars_sent - base < RANDOM_ITEMS) begin
			if (hdr_count % 8 == 0) begin
				burst_mode = ($urandom_range(0, 4) == 0);
			end
			if (hdr_count == 40) begin
				wait_drained();
			end
			fs = pick_file_size();
			build_header(fs);
			send_header(fs, $urandom_range(0, 19) == 0);
			hdr_count++;
		end
		hdr.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
